[sv/mxfp4_block_dot_accumulate_macros.svh]
// Assertion helpers used by the checker of this block.
`ifndef MXFP4_BLOCK_DOT_ACCUMULATE_MACROS_SVH
`define MXFP4_BLOCK_DOT_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBDA_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MBDA_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mbda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mbda_pkg;

  localparam int NLANES     = 4;
  localparam int LANE_ELEMS = 8;
  localparam int LSUM_W     = 15;
  localparam int SUM_W      = 17;
  localparam int RW         = 50;
  localparam int XW         = 12;
  localparam int PW         = 6;

  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic signed [XW-1:0] X_OFS   = 150;
  localparam logic signed [XW-1:0] E8_BIAS = 128;
  localparam logic signed [XW-1:0] T_MIN   = -149;
  localparam logic signed [XW-1:0] MANT_X  = 23;
  localparam logic signed [XW-1:0] SH_MAX  = 51;
  localparam logic signed [XW-1:0] ALIGN_X = 24;
  localparam logic signed [XW-1:0] ALIGN_W = 48;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LANE, ST_MERGE, ST_MUL1_W, ST_MUL2, ST_MUL2_W0, ST_MUL2_W1,
    ST_ADD, ST_ADD_W0, ST_ADD_W1, ST_DONE
  } state_t;

  // Request to the rounding unit: value = mag * 2^xp, or a fixed special.
  typedef struct packed {
    logic                 s;
    logic [RW-1:0]        mag;
    logic signed [XW-1:0] xp;
    logic                 spec;
    logic [31:0]          spec_bits;
  } rnd_req_t;

  function automatic logic signed [4:0] fp4_value(input logic [3:0] code);
    logic signed [4:0] v;
    unique case (code)
      4'd0:  v = 5'sd0;
      4'd1:  v = 5'sd1;
      4'd2:  v = 5'sd2;
      4'd3:  v = 5'sd3;
      4'd4:  v = 5'sd4;
      4'd5:  v = 5'sd6;
      4'd6:  v = 5'sd8;
      4'd7:  v = 5'sd12;
      4'd8:  v = 5'sd0;
      4'd9:  v = -5'sd1;
      4'd10: v = -5'sd2;
      4'd11: v = -5'sd3;
      4'd12: v = -5'sd4;
      4'd13: v = -5'sd6;
      4'd14: v = -5'sd8;
      default: v = -5'sd12;
    endcase
    return v;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (&f[30:23]) && !(|f[22:0]);
  endfunction

  function automatic logic [23:0] mant24(input logic [31:0] f);
    return {|f[30:23], f[22:0]};
  endfunction

  // Exponent of the mantissa LSB.
  function automatic logic signed [XW-1:0] lsb_exp(input logic [31:0] f);
    logic [7:0] eu;
    eu = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    return $signed({{(XW-8){1'b0}}, eu}) - X_OFS;
  endfunction

endpackage
`default_nettype wire

[sv/mbda_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface mbda_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] weight_nibbles_lo;
  logic [63:0] weight_nibbles_hi;
  logic [63:0] acts_0_7;
  logic [63:0] acts_8_15;
  logic [63:0] acts_16_23;
  logic [63:0] acts_24_31;
  logic [7:0]  scale_exponent;
  logic [31:0] act_scale;
  logic        last_block;

  modport source(output valid, weight_nibbles_lo, weight_nibbles_hi, acts_0_7, acts_8_15,
                 acts_16_23, acts_24_31, scale_exponent, act_scale, last_block,
                 input ready);
  modport sink(input valid, weight_nibbles_lo, weight_nibbles_hi, acts_0_7, acts_8_15,
               acts_16_23, acts_24_31, scale_exponent, act_scale, last_block,
               output ready);
endinterface

interface mbda_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_sum;

  modport source(output valid, row_sum, input ready);
  modport sink(input valid, row_sum, output ready);
endinterface
`default_nettype wire

[sv/mbda_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbda_lane import mbda_pkg::*; (
  input  logic [LANE_ELEMS-1:0][3:0] codes,
  input  logic [LANE_ELEMS-1:0][7:0] acts,
  output logic signed [LSUM_W-1:0]   sum
);

  // Exact integer dot product of this lane's elements.
  always_comb begin
    logic signed [12:0] pr;
    sum = '0;
    for (int k = 0; k < LANE_ELEMS; k++) begin
      pr  = fp4_value(codes[k]) * $signed(acts[k]);
      sum = sum + pr;
    end
  end

endmodule
`default_nettype wire

[sv/mbda_round.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbda_round import mbda_pkg::*; (
  input  logic        clk,
  input  rnd_req_t    req,
  output logic [31:0] res
);

  rnd_req_t             s1;
  logic signed [XW-1:0] s1_t;
  logic signed [XW-1:0] s1_sh;
  logic                 s1_nz;

  // Stage 1: find the leading one and the target LSB exponent.
  always_ff @(posedge clk) begin
    logic [PW-1:0]        p;
    logic signed [XW-1:0] tn;
    logic signed [XW-1:0] t;
    p = '0;
    for (int i = 0; i < RW; i++) begin
      if (req.mag[i]) p = PW'(i);
    end
    tn = $signed({{(XW-PW){1'b0}}, p}) + req.xp - MANT_X;
    t  = (tn < T_MIN) ? T_MIN : tn;
    s1    <= req;
    s1_t  <= t;
    s1_sh <= t - req.xp;
    s1_nz <= |req.mag;
  end

  // Stage 2: shift, round to nearest even, pack.
  always_ff @(posedge clk) begin
    logic [2*RW-1:0]      ext;
    logic [RW-1:0]        shl_v;
    logic signed [XW-1:0] shc;
    logic signed [XW-1:0] nsh;
    logic [24:0]          r;
    logic                 g;
    logic                 st;
    logic [24:0]          rr;
    logic [XW-1:0]        tb;
    logic [40:0]          pk;
    ext   = '0;
    shl_v = '0;
    if (s1_sh <= $signed({XW{1'b0}})) begin
      nsh   = -s1_sh;
      shl_v = s1.mag << nsh[4:0];
      r     = shl_v[24:0];
      g     = 1'b0;
      st    = 1'b0;
    end else begin
      shc = (s1_sh > SH_MAX) ? SH_MAX : s1_sh;
      ext = {s1.mag, {RW{1'b0}}} >> shc[PW-1:0];
      r   = ext[RW+24:RW];
      g   = ext[RW-1];
      st  = (|ext[RW-2:0]) || ((s1_sh > SH_MAX) && s1_nz);
    end
    rr = r + 25'(g && (st || r[0]));
    tb = s1_t - T_MIN;
    pk = ({29'd0, tb} << 23) + {16'd0, rr};
    if (s1.spec) begin
      res <= s1.spec_bits;
    end else if (!s1_nz) begin
      res <= {s1.s, 31'd0};
    end else if (pk >= 41'h7F800000) begin
      res <= {s1.s, 8'hFF, 23'd0};
    end else begin
      res <= {s1.s, pk[30:0]};
    end
  end

endmodule
`default_nettype wire

[sv/mxfp4_block_dot_accumulate.sv]
`timescale 1ns / 1ps
`default_nettype none
// MXFP4 x INT8 block dot product with a running FP32 row accumulator. Each request is one
// 32-element block: 16 bytes of E2M1 weight nibbles, an E8M0 exponent, 32 int8 activations
// and an FP32 activation scale. Four lanes of eight elements form exact integer partial
// sums, a merge stage adds them, and one shared two-stage FP32 rounding unit then performs,
// in turn, scale * act_scale, that product times the integer sum, and the accumulate, each
// rounded to nearest even with subnormals kept. A request marked last_block emits row_sum
// (NaN as 0x7FC00000) and clears the accumulator to +0.0; other requests emit nothing.
// Blocks are taken one at a time: a new request is accepted only once the previous block
// has gone through the accept, three passes through the rounding unit (the first is issued
// from the lane state and overlaps the merge) and the write-back. The result sits in an output register,
// so the next block is accepted while a row_sum waits to be taken; a later last block holds
// in its write-back state until that earlier row_sum has been taken.
module mxfp4_block_dot_accumulate import mbda_pkg::*; (
  input logic     clk,
  input logic     rst,
  mbda_in_if.sink   in_ch,
  mbda_out_if.source out_ch
);

  state_t state, state_next;

  // Held block
  logic [63:0]                   w_lo, w_hi;
  logic [NLANES-1:0][63:0]       acts_r;
  logic [7:0]                    exp_r;
  logic [31:0]                   xs_r;
  logic                          last_r;

  logic signed [LSUM_W-1:0]      lane_sum [NLANES];
  logic signed [LSUM_W-1:0]      lane_reg [NLANES];
  logic signed [SUM_W-1:0]       sum;

  rnd_req_t                      rnd_req, rq_mul1, rq_mul2, rq_add;
  logic [31:0]                   rnd_res;
  logic [31:0]                   acc;
  logic                          out_valid;
  logic [31:0]                   out_sum;
  logic                          accept;
  logic                          load_out;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.row_sum = out_sum;

  // Lanes: lanes 0/1 take low nibbles of bytes 0..7 / 8..15, lanes 2/3 the high nibbles.
  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    logic [LANE_ELEMS-1:0][3:0] codes;
    for (genvar k = 0; k < LANE_ELEMS; k++) begin : g_el
      logic [63:0] wword;
      logic [7:0]  wbyte;
      assign wword    = (l % 2 == 1) ? w_hi : w_lo;
      assign wbyte    = wword[8*k +: 8];
      assign codes[k] = (l / 2 == 1) ? wbyte[7:4] : wbyte[3:0];
    end
    mbda_lane u_lane (
      .codes(codes),
      .acts (acts_r[l]),
      .sum  (lane_sum[l])
    );
  end

  mbda_round u_round (
    .clk(clk),
    .req(rnd_req),
    .res(rnd_res)
  );

  // First pass: act_scale times 2^(e-128); the block scale only moves the exponent.
  always_comb begin
    rq_mul1.s         = xs_r[31];
    rq_mul1.mag       = RW'(mant24(xs_r));
    rq_mul1.xp        = lsb_exp(xs_r) + $signed({{(XW-8){1'b0}}, exp_r}) - E8_BIAS;
    rq_mul1.spec      = is_nan(xs_r) || is_inf(xs_r);
    rq_mul1.spec_bits = is_nan(xs_r) ? QNAN : {xs_r[31], 8'hFF, 23'd0};
  end

  // Second pass: scaled product times the integer block sum.
  always_comb begin
    logic        ss;
    logic [15:0] abs_sum;
    logic [39:0] prod;
    ss      = sum[SUM_W-1];
    abs_sum = ss ? 16'(-sum) : 16'(sum);
    prod    = mant24(rnd_res) * abs_sum;
    rq_mul2.s    = rnd_res[31] ^ ss;
    rq_mul2.mag  = RW'(prod);
    rq_mul2.xp   = lsb_exp(rnd_res);
    rq_mul2.spec = is_nan(rnd_res) || is_inf(rnd_res);
    if (is_nan(rnd_res) || (sum == '0)) begin
      rq_mul2.spec_bits = QNAN;
    end else begin
      rq_mul2.spec_bits = {rnd_res[31] ^ ss, 8'hFF, 23'd0};
    end
  end

  // Third pass: accumulator plus term, aligned on the larger exponent with sticky.
  always_comb begin
    logic                 a_big;
    logic signed [XW-1:0] xa, xb, xbig, d;
    logic [23:0]          mbig, msml;
    logic                 sbig, ssml;
    logic [47:0]          bs, bal;
    logic                 stk;
    logic [RW-1:0]        ma, mb;
    xa    = lsb_exp(acc);
    xb    = lsb_exp(rnd_res);
    a_big = (xa >= xb);
    xbig  = a_big ? xa : xb;
    d     = a_big ? (xa - xb) : (xb - xa);
    mbig  = a_big ? mant24(acc) : mant24(rnd_res);
    msml  = a_big ? mant24(rnd_res) : mant24(acc);
    sbig  = a_big ? acc[31] : rnd_res[31];
    ssml  = a_big ? rnd_res[31] : acc[31];
    bs    = {msml, 24'd0};
    if (d >= ALIGN_W) begin
      bal = '0;
      stk = |msml;
    end else begin
      bal = bs >> d[5:0];
      stk = ((bal << d[5:0]) != bs);
    end
    ma = RW'({mbig, 24'd0});
    mb = RW'(bal | 48'(stk));
    if (sbig == ssml) begin
      rq_add.mag = ma + mb;
      rq_add.s   = sbig;
    end else if (ma >= mb) begin
      rq_add.mag = ma - mb;
      rq_add.s   = sbig;
    end else begin
      rq_add.mag = mb - ma;
      rq_add.s   = ssml;
    end
    // exact cancellation gives +0
    if ((rq_add.mag == '0) && (sbig != ssml)) rq_add.s = 1'b0;
    rq_add.xp = xbig - ALIGN_X;
    rq_add.spec = is_nan(acc) || is_nan(rnd_res) || is_inf(acc) || is_inf(rnd_res);
    if (is_nan(acc) || is_nan(rnd_res) ||
        (is_inf(acc) && is_inf(rnd_res) && (acc[31] != rnd_res[31]))) begin
      rq_add.spec_bits = QNAN;
    end else if (is_inf(acc)) begin
      rq_add.spec_bits = acc;
    end else begin
      rq_add.spec_bits = rnd_res;
    end
  end

  // Hold the final stage until the output register is free.
  assign load_out = (state == ST_DONE) && last_r && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_LANE;
      ST_LANE:    state_next = ST_MERGE;
      ST_MERGE:   state_next = ST_MUL1_W;
      ST_MUL1_W:  state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_MUL2_W0;
      ST_MUL2_W0: state_next = ST_MUL2_W1;
      ST_MUL2_W1: state_next = ST_ADD;
      ST_ADD:     state_next = ST_ADD_W0;
      ST_ADD_W0:  state_next = ST_ADD_W1;
      ST_ADD_W1:  state_next = ST_DONE;
      ST_DONE:    if (!last_r || load_out) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath registers: payload, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      w_lo      <= in_ch.weight_nibbles_lo;
      w_hi      <= in_ch.weight_nibbles_hi;
      acts_r[0] <= in_ch.acts_0_7;
      acts_r[1] <= in_ch.acts_8_15;
      acts_r[2] <= in_ch.acts_16_23;
      acts_r[3] <= in_ch.acts_24_31;
      exp_r     <= in_ch.scale_exponent;
      xs_r      <= in_ch.act_scale;
      last_r    <= in_ch.last_block;
    end
    if (state == ST_LANE) begin
      for (int l = 0; l < NLANES; l++) lane_reg[l] <= lane_sum[l];
      rnd_req <= rq_mul1;
    end
    if (state == ST_MERGE) begin
      sum <= SUM_W'(lane_reg[0]) + SUM_W'(lane_reg[1]) +
             SUM_W'(lane_reg[2]) + SUM_W'(lane_reg[3]);
    end
    if (state == ST_MUL2) rnd_req <= rq_mul2;
    if (state == ST_ADD)  rnd_req <= rq_add;
    if (load_out) out_sum <= rnd_res;
  end

  // Accumulator and output valid: control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      if ((state == ST_DONE) && !last_r) acc <= rnd_res;
      if (load_out) acc <= '0;
    end
  end

endmodule
`default_nettype wire

[sv/mbda_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mxfp4_block_dot_accumulate_macros.svh"
module mbda_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_row_sum
);

  // stalled result stays offered and unchanged
  `MBDA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "row_sum dropped")
  `MBDA_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_row_sum), "row_sum changed")
  // one block at a time
  `MBDA_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "request taken while busy")
  // a block that does not close a row gives no result
  `MBDA_ASSERT_NXT(a_no_extra, clk, rst, in_valid && in_ready && !in_last, !$rose(out_valid), "spurious row_sum")

endmodule

bind mxfp4_block_dot_accumulate mbda_checker u_mbda_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_block),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_row_sum(out_ch.row_sum)
);
`default_nettype wire

[test/tb_mxfp4_block_dot_accumulate.sv]
`timescale 1ns / 1ps
module tb_mxfp4_block_dot_accumulate;
  import mbda_pkg::*;

  // One 32-element block as it travels over the request channel.
  typedef struct {
    bit [63:0] nib_lo;
    bit [63:0] nib_hi;
    bit [63:0] acts [4];
    bit [7:0]  exp_e8;
    bit [31:0] act_scale;
    bit        last;
  } block_t;

  logic clk;
  logic rst;

  mbda_in_if  in_ch ();
  mbda_out_if out_ch ();

  mxfp4_block_dot_accumulate u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  block_t    pending_blocks[$];
  bit [31:0] row_sums_due[$];
  bit [31:0] row_acc;
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // FP32 arithmetic done exactly on wide integers, then rounded once to nearest
  // even. Every value is sign, magnitude and the exponent of the magnitude LSB.
  // ---------------------------------------------------------------------------
  function automatic bit [31:0] fp32_round(bit s, bit [319:0] mag, int xp);
    int        p;
    int        lsb;
    int        sh;
    bit [319:0] m;
    bit [319:0] mask;
    bit        rb;
    bit        st;
    p = -1;
    for (int k = 0; k < 320; k++) if (mag[k]) p = k;
    if (p < 0) return {s, 31'b0};
    // Keep 24 significant bits, but never go below the subnormal LSB.
    lsb = xp + p - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - xp;
    if (sh <= 0) begin
      m = mag << (-sh);
    end else begin
      m    = mag >> sh;
      rb   = mag[sh-1];
      mask = ~({320{1'b1}} << (sh - 1));
      st   = |(mag & mask);
      if (rb && (st || m[0])) m = m + 1;
    end
    // Rounding carried into a new bit: renormalize.
    if (m[24]) begin
      m = m >> 1;
      lsb++;
    end
    if (m[23]) begin
      if (lsb + 150 >= 255) return {s, 8'hFF, 23'b0};
      return {s, 8'(lsb + 150), m[22:0]};
    end
    return {s, 8'h00, m[22:0]};
  endfunction

  function automatic bit fp32_nan(bit [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  function automatic bit fp32_inf(bit [31:0] f);
    return (&f[30:23]) && !(|f[22:0]);
  endfunction

  function automatic void fp32_split(bit [31:0] f, output bit [23:0] m, output int x);
    m = {|f[30:23], f[22:0]};
    x = ((f[30:23] == 8'd0) ? 1 : int'(f[30:23])) - 150;
  endfunction

  function automatic bit [31:0] fp32_mul(bit [31:0] a, bit [31:0] b);
    bit        s;
    bit [23:0] ma;
    bit [23:0] mb;
    int        xa;
    int        xb;
    bit [319:0] mag;
    s = a[31] ^ b[31];
    if (fp32_nan(a) || fp32_nan(b)) return QNAN;
    if ((fp32_inf(a) && b[30:0] == 0) || (fp32_inf(b) && a[30:0] == 0)) return QNAN;
    if (fp32_inf(a) || fp32_inf(b)) return {s, 8'hFF, 23'b0};
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'b0};
    fp32_split(a, ma, xa);
    fp32_split(b, mb, xb);
    mag = 320'(ma) * 320'(mb);
    return fp32_round(s, mag, xa + xb);
  endfunction

  function automatic bit [31:0] fp32_add(bit [31:0] a, bit [31:0] b);
    bit [23:0] ma;
    bit [23:0] mb;
    int        xa;
    int        xb;
    int        xm;
    bit [319:0] wa;
    bit [319:0] wb;
    if (fp32_nan(a) || fp32_nan(b)) return QNAN;
    if (fp32_inf(a) && fp32_inf(b)) return (a[31] == b[31]) ? a : QNAN;
    if (fp32_inf(a)) return a;
    if (fp32_inf(b)) return b;
    // Zero plus zero keeps the sign only when both are negative.
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    fp32_split(a, ma, xa);
    fp32_split(b, mb, xb);
    xm = (xa < xb) ? xa : xb;
    wa = 320'(ma) << (xa - xm);
    wb = 320'(mb) << (xb - xm);
    if (a[31] == b[31]) return fp32_round(a[31], wa + wb, xm);
    if (wa == wb) return 32'h0;
    if (wa > wb) return fp32_round(a[31], wa - wb, xm);
    return fp32_round(b[31], wb - wa, xm);
  endfunction

  // Doubled E2M1 value; the halving lives in the block exponent.
  function automatic int e2m1_doubled(bit [3:0] code);
    int mag;
    case (code[2:0])
      3'd0: mag = 0;
      3'd1: mag = 1;
      3'd2: mag = 2;
      3'd3: mag = 3;
      3'd4: mag = 4;
      3'd5: mag = 6;
      3'd6: mag = 8;
      default: mag = 12;
    endcase
    return code[3] ? -mag : mag;
  endfunction

  // Fold one block into the row accumulator; return 1 and the row sum on the
  // last block of a row.
  function automatic bit accumulate_block(block_t b, output bit [31:0] row_sum);
    int        sum;
    bit [7:0]  wbyte;
    bit [31:0] e8_bits;
    bit [31:0] sum_bits;
    bit [31:0] term;
    sum = 0;
    for (int i = 0; i < 16; i++) begin
      wbyte = (i < 8) ? b.nib_lo[(i%8)*8 +: 8] : b.nib_hi[(i%8)*8 +: 8];
      sum += e2m1_doubled(wbyte[3:0]) * int'($signed(b.acts[i/8][(i%8)*8 +: 8]));
      sum += e2m1_doubled(wbyte[7:4]) * int'($signed(b.acts[(i+16)/8][(i%8)*8 +: 8]));
    end
    // E8M0 to FP32: the two lowest codes land in the subnormal range.
    if (b.exp_e8 < 2) e8_bits = 32'h0020_0000 << b.exp_e8;
    else e8_bits = 32'(b.exp_e8 - 1) << 23;
    sum_bits = fp32_round(sum < 0, 320'(sum < 0 ? -sum : sum), 0);
    term     = fp32_mul(fp32_mul(e8_bits, b.act_scale), sum_bits);
    row_acc  = fp32_add(row_acc, term);
    row_sum  = fp32_nan(row_acc) ? QNAN : row_acc;
    if (!b.last) return 1'b0;
    row_acc = 32'h0;
    return 1'b1;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random block. Tame blocks keep the scales near unity so rows stay finite;
  // wild ones draw every field over its whole range.
  function automatic block_t make_block(bit last, bit wild);
    block_t b;
    b.nib_lo = rand64();
    b.nib_hi = rand64();
    for (int k = 0; k < 4; k++) b.acts[k] = rand64();
    if (wild) begin
      b.exp_e8    = 8'($urandom_range(0, 255));
      b.act_scale = $urandom;
    end else begin
      b.exp_e8    = 8'($urandom_range(110, 146));
      b.act_scale = {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    end
    b.last = last;
    return b;
  endfunction

  function automatic block_t fill_block(bit [7:0] nib, bit [7:0] act, bit [7:0] e8,
                                        bit [31:0] xs, bit last);
    block_t b;
    b.nib_lo = {8{nib}};
    b.nib_hi = {8{nib}};
    for (int k = 0; k < 4; k++) b.acts[k] = {8{act}};
    b.exp_e8    = e8;
    b.act_scale = xs;
    b.last      = last;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: advance to the next pending block when the channel is free, idling
  // at random as the current phase asks.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    block_t nb;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = pending_blocks.pop_front();
        in_ch.valid             <= 1'b1;
        in_ch.weight_nibbles_lo <= nb.nib_lo;
        in_ch.weight_nibbles_hi <= nb.nib_hi;
        in_ch.acts_0_7          <= nb.acts[0];
        in_ch.acts_8_15         <= nb.acts[1];
        in_ch.acts_16_23        <= nb.acts[2];
        in_ch.acts_24_31        <= nb.acts[3];
        in_ch.scale_exponent    <= nb.exp_e8;
        in_ch.act_scale         <= nb.act_scale;
        in_ch.last_block        <= nb.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted row sum.
  always @(posedge clk) begin
    block_t    b;
    bit [31:0] sum_bits;
    bit [31:0] want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        b.nib_lo    = in_ch.weight_nibbles_lo;
        b.nib_hi    = in_ch.weight_nibbles_hi;
        b.acts[0]   = in_ch.acts_0_7;
        b.acts[1]   = in_ch.acts_8_15;
        b.acts[2]   = in_ch.acts_16_23;
        b.acts[3]   = in_ch.acts_24_31;
        b.exp_e8    = in_ch.scale_exponent;
        b.act_scale = in_ch.act_scale;
        b.last      = in_ch.last_block;
        if (accumulate_block(b, sum_bits)) row_sums_due.push_back(sum_bits);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (row_sums_due.size() == 0) begin
          report_mismatch($sformatf("unexpected row_sum %h", out_ch.row_sum));
        end else begin
          want = row_sums_due.pop_front();
          if (out_ch.row_sum !== want)
            report_mismatch($sformatf("row_sum %h, expected %h", out_ch.row_sum, want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------
  initial begin
    block_t    d;
    int        row_len;
    int        sent;
    bit        wild;
    errors        = 0;
    row_acc       = 32'h0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst           = 1'b1;
    in_ch.valid             = 1'b0;
    in_ch.weight_nibbles_lo = '0;
    in_ch.weight_nibbles_hi = '0;
    in_ch.acts_0_7          = '0;
    in_ch.acts_8_15         = '0;
    in_ch.acts_16_23        = '0;
    in_ch.acts_24_31        = '0;
    in_ch.scale_exponent    = '0;
    in_ch.act_scale         = '0;
    in_ch.last_block        = 1'b0;
    out_ch.ready            = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: largest sums of both signs, largest and smallest exponents.
    pending_blocks.push_back(fill_block(8'h77, 8'h80, 8'd128, 32'h3F80_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'hFF, 8'h80, 8'd255, 32'h7F7F_FFFF, 1'b1));
    pending_blocks.push_back(fill_block(8'hFF, 8'h7F, 8'd255, 32'h3F80_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h11, 8'h01, 8'd0, 32'h0000_0001, 1'b1));
    pending_blocks.push_back(fill_block(8'h77, 8'h7F, 8'd1, 32'h3F80_0000, 1'b0));
    pending_blocks.push_back(fill_block(8'h99, 8'h7F, 8'd0, 32'h4000_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h76, 8'h05, 8'd1, 32'h7F7F_FFFF, 1'b1));
    // NaN scale, infinity times zero, infinities of both signs.
    pending_blocks.push_back(fill_block(8'h33, 8'h11, 8'd128, 32'h7FA0_0001, 1'b1));
    pending_blocks.push_back(fill_block(8'h00, 8'h00, 8'd128, 32'h7F80_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h88, 8'h55, 8'd128, 32'hFF80_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h77, 8'h7F, 8'd128, 32'h7F80_0000, 1'b0));
    pending_blocks.push_back(fill_block(8'h77, 8'h7F, 8'd128, 32'hFF80_0000, 1'b1));
    // Exact cancellation across a row, and a negative zero term.
    pending_blocks.push_back(fill_block(8'h25, 8'h13, 8'd130, 32'h3FC0_0000, 1'b0));
    pending_blocks.push_back(fill_block(8'hAD, 8'h13, 8'd130, 32'h3FC0_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h00, 8'h00, 8'd128, 32'h8000_0000, 1'b1));
    pending_blocks.push_back(fill_block(8'h00, 8'h00, 8'd128, 32'h8000_0000, 1'b0));
    pending_blocks.push_back(fill_block(8'h44, 8'h00, 8'd128, 32'hBF80_0000, 1'b1));
    // Every weight code against a mix of activation signs.
    d = fill_block(8'h00, 8'h00, 8'd127, 32'h3F80_0000, 1'b1);
    d.nib_lo  = 64'h7654_3210_FEDC_BA98;
    d.nib_hi  = 64'hBA98_FEDC_3210_7654;
    d.acts[0] = 64'h8001_7FFF_0203_FE81;
    d.acts[1] = 64'h0102_0304_0506_0708;
    d.acts[2] = 64'hF8F9_FAFB_FCFD_FEFF;
    d.acts[3] = 64'h7F80_7F80_0102_FDFE;
    pending_blocks.push_back(d);

    // Random rows, one phase per idling mix. Pause between phases until the
    // block has drained so the sender also sits idle for a long stretch.
    for (int phase = 0; phase < 4; phase++) begin
      while (pending_blocks.size() != 0 || in_ch.valid || row_sums_due.size() != 0)
        @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 58; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 58; end
        default: begin send_idle_pct = 21; recv_idle_pct = 21; end
      endcase
      sent = 0;
      while (sent < 450) begin
        row_len = $urandom_range(1, 6);
        wild    = ($urandom_range(99) < 15);
        for (int k = 0; k < row_len; k++)
          pending_blocks.push_back(make_block(k == row_len - 1, wild));
        sent += row_len;
      end
    end

    while (pending_blocks.size() != 0 || in_ch.valid || row_sums_due.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && row_sums_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
